// ----- rtl/rational_arith_unit_assert.svh -----
// assertion macros used by the rational unit back end
`ifndef RATIONAL_ARITH_UNIT_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RAU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rational unit check failed");

// next-cycle implication, checked outside reset
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rational unit check failed");

`endif

// ----- rtl/rau_pkg.sv -----
// types, constants and helpers of the rational arithmetic unit
package rau_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FLD_W = 32;
    localparam int DEN_W = 31;
    localparam int ACC_W = 2 * FLD_W;
    localparam int SH_W  = $clog2(ACC_W);
    localparam int OP_W  = 3;
    localparam int ST_W  = 2;

    // opcodes
    localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
    localparam logic [OP_W-1:0] OP_LT   = 3'd4;
    localparam logic [OP_W-1:0] OP_EQ   = 3'd5;
    localparam logic [OP_W-1:0] OP_NORM = 3'd6;
    localparam logic [OP_W-1:0] OP_NONE = 3'd7;

    // status codes
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_DIVZ = 2'd1;
    localparam logic [ST_W-1:0] ST_OVF  = 2'd2;

    // overflow limits of the result range
    localparam logic [ACC_W-1:0] MAX_POS = ACC_W'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);
    localparam logic [ACC_W-1:0] MAX_NEG = ACC_W'(64'd1 << (VALUE_WIDTH - 1));

    // how the back end must treat a request
    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_BAD  = 2'd1,
        K_CALC = 2'd2
    } t_kind;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        t_kind                   kind;
        logic signed [FLD_W-1:0] an;
        logic signed [FLD_W-1:0] ad;
        logic signed [FLD_W-1:0] bn;
        logic [DEN_W-1:0]        bd;
    } t_req;

    // sign and magnitudes of a fraction in the wide domain
    typedef struct packed {
        logic             sign;
        logic [ACC_W-1:0] n;
        logic [ACC_W-1:0] d;
    } t_frac;

    function automatic logic [FLD_W-1:0] mag32(input logic signed [FLD_W-1:0] x);
        logic [FLD_W-1:0] u;
        u = x;
        return x[FLD_W-1] ? (~u + 1'b1) : u;
    endfunction

endpackage

// ----- rtl/rau_front.sv -----
// request intake stage: registers a request and classifies it
module rau_front import rau_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [OP_W-1:0]         i_req_type,
    input  logic signed [FLD_W-1:0] i_a_num,
    input  logic signed [FLD_W-1:0] i_a_den,
    input  logic signed [FLD_W-1:0] i_b_num,
    input  logic [DEN_W-1:0]        i_b_den,
    output logic                    o_valid,
    output t_req                    o_req,
    input  logic                    i_stall
);

    logic  r_valid;
    t_req  r_req;
    t_kind kind;

    // early-answer classes are settled here
    always_comb begin
        if (i_req_type == OP_NONE) begin
            kind = K_NONE;
        end else if (i_a_den == '0 || (i_req_type != OP_NORM && i_b_den == '0)) begin
            kind = K_BAD;
        end else if (i_req_type == OP_DIV && i_b_num == '0) begin
            kind = K_BAD;
        end else begin
            kind = K_CALC;
        end
    end

    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    // holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_req.op   <= i_req_type;
            r_req.kind <= kind;
            r_req.an   <= i_a_num;
            r_req.ad   <= i_a_den;
            r_req.bn   <= i_b_num;
            r_req.bd   <= i_b_den;
        end
    end

endmodule

// ----- rtl/rau_queue.sv -----
// two-entry request queue between front and back
module rau_queue import rau_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_req i_req,
    output logic o_stall,
    output logic o_valid,
    output t_req o_req,
    input  logic i_stall
);

    t_req       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_mem[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_req;
        end
    end

endmodule

// ----- rtl/rau_reduce.sv -----
// fraction reduction: binary gcd, then two restoring dividers by the gcd
module rau_reduce import rau_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_frac i_frac,
    output logic  o_done,
    output t_frac o_frac
);

    typedef enum logic [2:0] {
        R_IDLE = 3'b001,
        R_GCD  = 3'b010,
        R_DIV  = 3'b100
    } t_rstate;

    t_rstate          r_state;
    logic             r_done;
    logic             r_sign;
    logic [ACC_W-1:0] r_u;
    logic [ACC_W-1:0] r_v;
    logic [SH_W-1:0]  r_k;
    logic [ACC_W-1:0] r_g;
    logic [ACC_W-1:0] r_qn;
    logic [ACC_W-1:0] r_qd;
    logic [ACC_W-1:0] r_remn;
    logic [ACC_W-1:0] r_remd;
    logic [SH_W-1:0]  r_cnt;

    logic [ACC_W+1:0] diff_n;
    logic [ACC_W+1:0] diff_d;
    logic             ge_n;
    logic             ge_d;

    // trial subtraction of both dividers
    assign diff_n = {1'b0, r_remn, r_qn[ACC_W-1]} - {2'b00, r_g};
    assign diff_d = {1'b0, r_remd, r_qd[ACC_W-1]} - {2'b00, r_g};
    assign ge_n   = !diff_n[ACC_W+1];
    assign ge_d   = !diff_d[ACC_W+1];

    assign o_done = r_done;
    assign o_frac = '{sign: r_sign, n: r_qn, d: r_qd};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                R_IDLE: begin
                    if (i_start) begin
                        if (i_frac.n == '0) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= R_GCD;
                        end
                    end
                end
                R_GCD: begin
                    if (r_u == '0 || r_v == '0) begin
                        r_state <= R_DIV;
                    end
                end
                R_DIV: begin
                    if (r_cnt == '1) begin
                        r_state <= R_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                    r_state <= R_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            R_IDLE: begin
                if (i_start) begin
                    if (i_frac.n == '0) begin
                        r_sign <= 1'b0;
                        r_qn   <= '0;
                        r_qd   <= ACC_W'(1);
                    end else begin
                        r_sign <= i_frac.sign;
                        r_qn   <= i_frac.n;
                        r_qd   <= i_frac.d;
                        r_u    <= i_frac.n;
                        r_v    <= i_frac.d;
                        r_k    <= '0;
                    end
                end
            end
            R_GCD: begin
                if (r_u == '0 || r_v == '0) begin
                    r_g    <= (r_u | r_v) << r_k;
                    r_remn <= '0;
                    r_remd <= '0;
                    r_cnt  <= '0;
                end else begin
                    // one binary gcd step
                    case ({r_u[0], r_v[0]})
                        2'b00: begin
                            r_u <= r_u >> 1;
                            r_v <= r_v >> 1;
                            r_k <= r_k + 1'b1;
                        end
                        2'b01: begin
                            r_u <= r_u >> 1;
                        end
                        2'b10: begin
                            r_v <= r_v >> 1;
                        end
                        default: begin
                            if (r_u >= r_v) begin
                                r_u <= (r_u - r_v) >> 1;
                            end else begin
                                r_v <= (r_v - r_u) >> 1;
                            end
                        end
                    endcase
                end
            end
            R_DIV: begin
                // one quotient bit per cycle for numerator and denominator
                r_remn <= ge_n ? diff_n[ACC_W-1:0] : {r_remn[ACC_W-2:0], r_qn[ACC_W-1]};
                r_remd <= ge_d ? diff_d[ACC_W-1:0] : {r_remd[ACC_W-2:0], r_qd[ACC_W-1]};
                r_qn   <= {r_qn[ACC_W-2:0], ge_n};
                r_qd   <= {r_qd[ACC_W-2:0], ge_d};
                r_cnt  <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- rtl/rau_back.sv -----
// execution sequencer: operand reduction, products, result reduction, range check
module rau_back import rau_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_req                    i_req,
    output logic                    o_stall,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [FLD_W-1:0] o_res_num,
    output logic [DEN_W-1:0]        o_res_den,
    output logic                    o_cmp_true,
    output logic [ST_W-1:0]         o_status
);

`include "rational_arith_unit_assert.svh"

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RA   = 9'b000000010,
        S_RB   = 9'b000000100,
        S_M1   = 9'b000001000,
        S_M2   = 9'b000010000,
        S_M3   = 9'b000100000,
        S_COMB = 9'b001000000,
        S_RR   = 9'b010000000,
        S_FIT  = 9'b100000000
    } t_state;

    t_state           r_state;
    t_req             r_req;
    logic             r_as;
    logic [FLD_W-1:0] r_an;
    logic [FLD_W-1:0] r_ad;
    logic             r_bs;
    logic [FLD_W-1:0] r_bn;
    logic [FLD_W-1:0] r_bd;
    logic [ACC_W-1:0] r_p1;
    logic [ACC_W-1:0] r_p2;
    logic [ACC_W-1:0] r_p3;
    t_frac            r_res;
    logic             r_red_start;
    t_frac            r_red_in;

    logic                    r_out_valid;
    logic signed [FLD_W-1:0] r_num;
    logic [DEN_W-1:0]        r_den;
    logic                    r_cmp;
    logic [ST_W-1:0]         r_st;

    logic             red_done;
    t_frac            red_out;
    logic             pop;
    logic [FLD_W-1:0] m_x;
    logic [FLD_W-1:0] m_y;
    logic [ACC_W-1:0] mul_p;
    logic signed [ACC_W:0] t1;
    logic signed [ACC_W:0] t2;
    logic signed [ACC_W:0] sum;
    logic [ACC_W-1:0] sum_mag;
    logic             fit_ok;
    logic [FLD_W-1:0] res_n32;

    rau_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_red_start),
        .i_frac  (r_red_in),
        .o_done  (red_done),
        .o_frac  (red_out)
    );

    assign pop     = (r_state == S_IDLE) && i_valid && !r_out_valid;
    assign o_stall = !((r_state == S_IDLE) && !r_out_valid);

    // shared multiplier operand select
    always_comb begin
        m_x = r_ad;
        m_y = r_bd;
        case (r_state)
            S_M1: begin
                m_x = r_an;
                m_y = (r_req.op == OP_MUL) ? r_bn : r_bd;
            end
            S_M2: begin
                if (r_req.op == OP_MUL) begin
                    m_x = r_ad;
                    m_y = r_bd;
                end else begin
                    m_x = r_ad;
                    m_y = r_bn;
                end
            end
            default: begin
                m_x = r_ad;
                m_y = r_bd;
            end
        endcase
    end

    assign mul_p = ACC_W'(m_x) * ACC_W'(m_y);

    // signed cross terms and their sum
    assign t1      = r_as ? -$signed({1'b0, r_p1}) : $signed({1'b0, r_p1});
    assign t2      = r_bs ? -$signed({1'b0, r_p2}) : $signed({1'b0, r_p2});
    assign sum     = (r_req.op == OP_SUB) ? (t1 - t2) : (t1 + t2);
    assign sum_mag = sum[ACC_W] ? ACC_W'(-sum) : sum[ACC_W-1:0];

    // result range check
    assign fit_ok  = (r_res.d <= MAX_POS) && (r_res.sign ? (r_res.n <= MAX_NEG)
                                                         : (r_res.n <= MAX_POS));
    assign res_n32 = r_res.n[FLD_W-1:0];

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_red_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_red_start <= 1'b0;
            if (o_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        case (i_req.kind)
                            K_CALC: begin
                                r_red_start <= 1'b1;
                                r_state     <= S_RA;
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_RA: begin
                    if (red_done) begin
                        if (r_req.op == OP_NORM) begin
                            r_state <= S_FIT;
                        end else begin
                            r_red_start <= 1'b1;
                            r_state     <= S_RB;
                        end
                    end
                end
                S_RB: begin
                    if (red_done) begin
                        if (r_req.op == OP_EQ) begin
                            r_out_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end else begin
                            r_state <= S_M1;
                        end
                    end
                end
                S_M1: begin
                    r_state <= S_M2;
                end
                S_M2: begin
                    if (r_req.op == OP_ADD || r_req.op == OP_SUB) begin
                        r_state <= S_M3;
                    end else begin
                        r_state <= S_COMB;
                    end
                end
                S_M3: begin
                    r_state <= S_COMB;
                end
                S_COMB: begin
                    if (r_req.op == OP_LT) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_red_start <= 1'b1;
                        r_state     <= S_RR;
                    end
                end
                S_RR: begin
                    if (red_done) begin
                        r_state <= S_FIT;
                    end
                end
                S_FIT: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (pop) begin
                    r_req          <= i_req;
                    r_red_in.sign  <= i_req.an[FLD_W-1] ^ i_req.ad[FLD_W-1];
                    r_red_in.n     <= ACC_W'(mag32(i_req.an));
                    r_red_in.d     <= ACC_W'(mag32(i_req.ad));
                    r_cmp          <= 1'b0;
                    r_num          <= '0;
                    if (i_req.kind == K_NONE) begin
                        r_den <= DEN_W'(1);
                        r_st  <= ST_OK;
                    end else begin
                        r_den <= '0;
                        r_st  <= ST_DIVZ;
                    end
                end
            end
            S_RA: begin
                if (red_done) begin
                    r_as          <= red_out.sign;
                    r_an          <= red_out.n[FLD_W-1:0];
                    r_ad          <= red_out.d[FLD_W-1:0];
                    r_res         <= red_out;
                    r_red_in.sign <= r_req.bn[FLD_W-1];
                    r_red_in.n    <= ACC_W'(mag32(r_req.bn));
                    r_red_in.d    <= ACC_W'(r_req.bd);
                end
            end
            S_RB: begin
                if (red_done) begin
                    r_bs  <= red_out.sign;
                    r_bn  <= red_out.n[FLD_W-1:0];
                    r_bd  <= red_out.d[FLD_W-1:0];
                    r_num <= '0;
                    r_den <= '0;
                    r_st  <= ST_OK;
                    r_cmp <= (r_as == red_out.sign) && (r_an == red_out.n[FLD_W-1:0])
                             && (r_ad == red_out.d[FLD_W-1:0]);
                end
            end
            S_M1: begin
                r_p1 <= mul_p;
            end
            S_M2: begin
                r_p2 <= mul_p;
            end
            S_M3: begin
                r_p3 <= mul_p;
            end
            S_COMB: begin
                r_num <= '0;
                r_den <= '0;
                r_st  <= ST_OK;
                r_cmp <= (t1 < t2);
                if (r_req.op == OP_ADD || r_req.op == OP_SUB) begin
                    r_red_in.sign <= sum[ACC_W];
                    r_red_in.n    <= sum_mag;
                    r_red_in.d    <= r_p3;
                end else begin
                    r_red_in.sign <= r_as ^ r_bs;
                    r_red_in.n    <= r_p1;
                    r_red_in.d    <= r_p2;
                end
            end
            S_RR: begin
                if (red_done) begin
                    r_res <= red_out;
                end
            end
            S_FIT: begin
                r_cmp <= 1'b0;
                if (fit_ok) begin
                    r_num <= r_res.sign ? $signed(~res_n32 + 1'b1) : $signed(res_n32);
                    r_den <= r_res.d[DEN_W-1:0];
                    r_st  <= ST_OK;
                end else begin
                    r_num <= '0;
                    r_den <= '0;
                    r_st  <= ST_OVF;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid    = r_out_valid;
    assign o_res_num  = r_num;
    assign o_res_den  = r_den;
    assign o_cmp_true = r_cmp;
    assign o_status   = r_st;

    // a request is taken only into an empty result slot
    `RAU_ASSERT_NOW(a_pop_slot_free, i_clk, i_rst_n, pop, !r_out_valid)
    // the reducer answers only while the sequencer waits for it
    `RAU_ASSERT_NOW(a_done_waiting, i_clk, i_rst_n, red_done,
        (r_state == S_RA) || (r_state == S_RB) || (r_state == S_RR))
    // the range check always delivers a result
    `RAU_ASSERT_NEXT(a_fit_delivers, i_clk, i_rst_n, r_state == S_FIT, r_out_valid)

endmodule

// ----- rtl/rational_arith_unit.sv -----
// rational arithmetic unit: each request passes the front register and the queue;
// an early answer (no opcode, zero denominator or zero divisor) then needs no reduction
// each reduction of a nonzero numerator runs a binary gcd (up to 128 steps) and a 64-step
// restoring divide; a computed request uses one to three reductions; the back end holds
// one request until its result is taken, so the single reduction unit sets the throughput
// reset is synchronous, active low, and clears all handshake and sequencer state
module rational_arith_unit import rau_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [OP_W-1:0]         i_req_type,
    input  logic signed [FLD_W-1:0] i_a_num,
    input  logic signed [FLD_W-1:0] i_a_den,
    input  logic signed [FLD_W-1:0] i_b_num,
    input  logic [DEN_W-1:0]        i_b_den,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [FLD_W-1:0] o_res_num,
    output logic [DEN_W-1:0]        o_res_den,
    output logic                    o_cmp_true,
    output logic [ST_W-1:0]         o_status
);

    logic f_valid;
    t_req f_req;
    logic q_stall;
    logic q_valid;
    t_req q_req;
    logic b_stall;

    rau_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_a_num    (i_a_num),
        .i_a_den    (i_a_den),
        .i_b_num    (i_b_num),
        .i_b_den    (i_b_den),
        .o_valid    (f_valid),
        .o_req      (f_req),
        .i_stall    (q_stall)
    );

    rau_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_req   (f_req),
        .o_stall (q_stall),
        .o_valid (q_valid),
        .o_req   (q_req),
        .i_stall (b_stall)
    );

    rau_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_req      (q_req),
        .o_stall    (b_stall),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_res_num  (o_res_num),
        .o_res_den  (o_res_den),
        .o_cmp_true (o_cmp_true),
        .o_status   (o_status)
    );

endmodule

// ----- tb/sv/tb.sv -----
// self-checking testbench of the rational arithmetic unit
module tb import rau_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3_000_000;

    typedef struct {
        logic [OP_W-1:0]         op;
        logic signed [FLD_W-1:0] an;
        logic signed [FLD_W-1:0] ad;
        logic signed [FLD_W-1:0] bn;
        logic [DEN_W-1:0]        bd;
    } t_in;

    typedef struct {
        logic signed [FLD_W-1:0] num;
        logic [DEN_W-1:0]        den;
        logic                    cmp;
        logic [ST_W-1:0]         st;
    } t_out;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic [OP_W-1:0]         i_req_type;
    logic signed [FLD_W-1:0] i_a_num;
    logic signed [FLD_W-1:0] i_a_den;
    logic signed [FLD_W-1:0] i_b_num;
    logic [DEN_W-1:0]        i_b_den;
    logic                    o_valid;
    logic                    i_stall;
    logic signed [FLD_W-1:0] o_res_num;
    logic [DEN_W-1:0]        o_res_den;
    logic                    o_cmp_true;
    logic [ST_W-1:0]         o_status;

    t_in  pending_reqs[$];
    t_out expected_fracs[$];
    int   send_idle_pct;
    int   recv_idle_pct;
    int   mismatches = 0;
    int   cycles = 0;
    bit   stim_done = 1'b0;
    bit   in_taken = 1'b0;

    rational_arith_unit dut (.*);

    // clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // euclid on magnitudes
    function automatic logic [127:0] gcd_mag(input logic [127:0] x, input logic [127:0] y);
        logic [127:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // lowest terms, positive denominator, zero as 0/1
    function automatic void lowest(inout longint signed n, inout longint signed d);
        longint signed g;
        if (n == 0) begin
            d = 1;
            return;
        end
        g = longint'(gcd_mag(n < 0 ? -n : n, d < 0 ? -d : d));
        n = n / g;
        d = d / g;
        if (d < 0) begin
            n = -n;
            d = -d;
        end
    endfunction

    // expected fraction or comparison for one request
    function automatic t_out rational_result(input t_in q);
        t_out r;
        longint signed an, ad, bn, bd, rn, rd, sn, g, l;
        r = '{num: '0, den: '0, cmp: 1'b0, st: ST_OK};
        an = q.an;
        ad = q.ad;
        bn = q.bn;
        bd = longint'({1'b0, q.bd});
        if (q.op == OP_NONE) begin
            r.den = 1;
            return r;
        end
        if (ad == 0 || (q.op != OP_NORM && bd == 0)) begin
            r.st = ST_DIVZ;
            return r;
        end
        lowest(an, ad);
        rn = an;
        rd = ad;
        if (q.op != OP_NORM) begin
            lowest(bn, bd);
            case (q.op)
                OP_LT: begin
                    r.cmp = (an * bd < bn * ad);
                    return r;
                end
                OP_EQ: begin
                    r.cmp = (an == bn && ad == bd);
                    return r;
                end
                OP_ADD, OP_SUB: begin
                    sn = (q.op == OP_SUB) ? -bn : bn;
                    if (ad == bd) begin
                        rn = an + sn;
                        rd = ad;
                    end else begin
                        g = longint'(gcd_mag(ad, bd));
                        l = (ad / g) * bd;
                        rn = an * (l / ad) + sn * (l / bd);
                        rd = l;
                    end
                end
                OP_MUL: begin
                    rn = an * bn;
                    rd = ad * bd;
                end
                default: begin
                    if (bn == 0) begin
                        r.st = ST_DIVZ;
                        return r;
                    end
                    rn = an * bd;
                    rd = ad * bn;
                end
            endcase
            lowest(rn, rd);
        end
        if (rn > 64'sd2147483647 || rn < -64'sd2147483648 || rd > 64'sd2147483647) begin
            r.st = ST_OVF;
            return r;
        end
        r.num = rn[31:0];
        r.den = rd[30:0];
        return r;
    endfunction

    // random operand values biased toward small magnitudes and edges
    function automatic logic signed [FLD_W-1:0] pick_val();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 0;
            3, 4: return $urandom;
            5, 6: return $signed($urandom_range(0, 65535)) - 32768;
            default: return $signed($urandom_range(0, 40)) - 20;
        endcase
    endfunction

    function automatic logic [DEN_W-1:0] pick_den();
        case ($urandom_range(0, 9))
            0: return 31'h7fff_ffff;
            1: return '0;
            2, 3: return DEN_W'($urandom);
            4, 5: return DEN_W'($urandom_range(1, 65535));
            default: return DEN_W'($urandom_range(1, 24));
        endcase
    endfunction

    // driver: new request at the falling edge unless still held
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            i_req_type <= OP_ADD;
            i_a_num    <= '0;
            i_a_den    <= 32'sd1;
            i_b_num    <= '0;
            i_b_den    <= 31'd1;
        end else if (!i_valid || in_taken) begin
            if (in_taken)
                void'(pending_reqs.pop_front());
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_valid    <= 1'b1;
                i_req_type <= pending_reqs[0].op;
                i_a_num    <= pending_reqs[0].an;
                i_a_den    <= pending_reqs[0].ad;
                i_b_num    <= pending_reqs[0].bn;
                i_b_den    <= pending_reqs[0].bd;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge i_clk) begin
        t_in  q;
        t_out e;
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            cycles <= cycles + 1;
            if (i_valid && !o_stall) begin
                q = '{op: i_req_type, an: i_a_num, ad: i_a_den, bn: i_b_num, bd: i_b_den};
                e = rational_result(q);
                expected_fracs = {expected_fracs, e};
            end
            if (o_valid && !i_stall) begin
                if (expected_fracs.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result %0d/%0d", o_res_num, o_res_den);
                end else begin
                    e = expected_fracs.pop_front();
                    if (o_res_num !== e.num || o_res_den !== e.den
                            || o_cmp_true !== e.cmp || o_status !== e.st) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d/%0d %0b %0d got %0d/%0d %0b %0d",
                                e.num, e.den, e.cmp, e.st,
                                o_res_num, o_res_den, o_cmp_true, o_status);
                    end
                end
            end
        end
    end

    task automatic add_req(input logic [OP_W-1:0] op, input logic signed [FLD_W-1:0] an,
            input logic signed [FLD_W-1:0] ad, input logic signed [FLD_W-1:0] bn,
            input logic [DEN_W-1:0] bd);
        t_in item;
        item = '{op: op, an: an, ad: ad, bn: bn, bd: bd};
        pending_reqs = {pending_reqs, item};
    endtask

    // random phase with the given idle rates
    task automatic run_phase(input int n, input int s_pct, input int r_pct);
        logic [OP_W-1:0] op;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (n) begin
            op = OP_W'($urandom_range(0, 7));
            add_req(op, pick_val(),
                ($urandom_range(0, 3) == 0) ? pick_val() : $signed({1'b0, pick_den()}),
                pick_val(), pick_den());
        end
        wait (pending_reqs.size() == 0);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        send_idle_pct = 23;
        recv_idle_pct = 54;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: each opcode, field extremes, error and overflow cases
        add_req(OP_ADD, 1, 2, 1, 3);
        add_req(OP_ADD, 1, 4, 1, 4);
        add_req(OP_SUB, 1, 2, 1, 2);
        add_req(OP_SUB, 32'sh8000_0000, 1, 32'sh7fff_ffff, 1);
        add_req(OP_ADD, 32'sh7fff_ffff, 1, 1, 1);
        add_req(OP_MUL, 2, 4, -3, 9);
        add_req(OP_MUL, 32'sh8000_0000, 1, 32'sh8000_0000, 1);
        add_req(OP_MUL, 1, 32'sh7fff_ffff, 1, 31'h7fff_ffff);
        add_req(OP_DIV, 1, 2, 0, 5);
        add_req(OP_DIV, -3, 4, -9, 8);
        add_req(OP_DIV, 32'sh8000_0000, 1, -1, 1);
        add_req(OP_LT, -1, 2, 1, 3);
        add_req(OP_LT, 1, 2, 2, 4);
        add_req(OP_EQ, 2, 4, 1, 2);
        add_req(OP_EQ, 1, 3, 1, 2);
        add_req(OP_NORM, 6, -8, 0, 0);
        add_req(OP_NORM, 0, -5, 7, 3);
        add_req(OP_NORM, 32'sh8000_0000, -1, 0, 0);
        add_req(OP_NORM, 32'sh8000_0000, 32'sh8000_0000, 0, 0);
        add_req(OP_NORM, 5, 0, 1, 1);
        add_req(OP_ADD, 1, 0, 1, 1);
        add_req(OP_SUB, 1, 1, 1, 0);
        add_req(OP_NONE, -1, 0, -1, 0);
        add_req(OP_EQ, 32'shffff_ffff, 32'sh7fff_ffff, 32'shffff_ffff, 31'h7fff_ffff);
        wait (pending_reqs.size() == 0);

        run_phase(550, 23, 54);
        run_phase(550, 54, 23);
        run_phase(550, 0, 0);
        stim_done = 1'b1;
    end

    // end of run and timeout
    initial begin
        wait (stim_done);
        wait (expected_fracs.size() == 0 || cycles >= CYCLE_LIMIT);
        if (cycles < CYCLE_LIMIT) begin
            repeat (700) @(posedge i_clk);
            if (mismatches == 0 && expected_fracs.size() == 0)
                $display("rational_arith_unit regression: pass");
            else
                $display("rational_arith_unit regression: fail");
            $finish;
        end
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("rational_arith_unit regression: fail");
        $finish;
    end

endmodule
